// File: rtl/tav_pkg.sv
package tav_pkg;

  typedef logic [7:0] sample_t;
  typedef logic [7:0] char_t;
  typedef logic [8:0] angle_t;
  typedef logic signed [8:0] contrib_t;

  // ASCII codes of the report line.
  localparam char_t CH_X     = 8'h78;
  localparam char_t CH_Y     = 8'h79;
  localparam char_t CH_Z     = 8'h7A;
  localparam char_t CH_EQ    = 8'h3D;
  localparam char_t CH_COMMA = 8'h2C;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_LF    = 8'h0A;

  // Angle scale 1.4117 as a 32-bit fraction, rounded up so that the
  // floor of the product matches the exact quotient for every byte.
  localparam int          ANGLE_FRAC   = 32;
  localparam int          ANGLE_MULT_W = 33;
  localparam logic [32:0] ANGLE_MULT   = 33'd6063205332;

  // A byte above 127 counts as byte minus 255.
  function automatic contrib_t tav_contrib(input sample_t b);
    contrib_t v;
    v = signed'({1'b0, b});
    if (b[7]) begin
      v = v - 9'sd255;
    end
    return v;
  endfunction

endpackage

// File: rtl/tav_in_if.sv
interface tav_in_if;
  import tav_pkg::*;

  logic    valid;
  logic    ready;
  logic    x_ready;
  logic    y_ready;
  sample_t x_sample;
  sample_t y_sample;

  modport source (output valid, x_ready, y_ready, x_sample, y_sample, input ready);
  modport sink   (input valid, x_ready, y_ready, x_sample, y_sample, output ready);
endinterface

// File: rtl/tav_out_if.sv
interface tav_out_if;
  import tav_pkg::*;

  logic  valid;
  logic  ready;
  char_t text_char;
  logic  line_end;

  modport source (output valid, text_char, line_end, input ready);
  modport sink   (input valid, text_char, line_end, output ready);
endinterface

// File: rtl/tav_ram.sv
module tav_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 10
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/tav_avg_div.sv
module tav_avg_div #(
  parameter int WINDOW = 10
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic signed [$clog2(127*WINDOW+1):0]     sum_i,
  output logic                                     done_o,
  output tav_pkg::sample_t                         avg_o
);
  import tav_pkg::*;

  localparam int SUM_W   = $clog2(127*WINDOW+1) + 1;
  localparam int SHIFT   = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W = SUM_W + 2;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // Reciprocal of WINDOW rounded up; its product gives the exact floor for
  // every dividend below 2**SUM_W.
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + WINDOW - 1) / WINDOW);

  logic              done_q;
  logic              neg_q;
  logic [SUM_W-1:0]  num_q;

  logic [SUM_W-1:0]  neg_sum;
  logic [SUM_W-1:0]  num_d;
  logic [PROD_W-1:0] prod;
  sample_t           quo;

  assign neg_sum = SUM_W'(-sum_i);
  // A negative sum rounds its magnitude up, so WINDOW - 1 is added before
  // the floor division.
  assign num_d   = sum_i[SUM_W-1] ? neg_sum + SUM_W'(WINDOW - 1) : $unsigned(sum_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      num_q  <= '0;
    end else begin
      done_q <= start_i;
      if (start_i) begin
        neg_q <= sum_i[SUM_W-1];
        num_q <= num_d;
      end
    end
  end

  // A negative sum folds into 255 minus its rounded-up quotient.
  assign prod   = PROD_W'(num_q) * PROD_W'(RECIP);
  assign quo    = prod[SHIFT +: 8];
  assign avg_o  = neg_q ? 8'd255 - quo : quo;
  assign done_o = done_q;

`ifndef SYNTHESIS
  a_done_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> done_q) else $error("divider result missing after start");
  a_done_only_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start_i |=> !done_q) else $error("divider result without a start");
  a_quo_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> quo <= 8'd127) else $error("quotient out of range");
  a_num_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> num_q < SUM_W'(128*WINDOW)) else $error("dividend out of range");
`endif

endmodule

// File: rtl/tilt_average_ascii_reporter.sv
// Tilt average reporter.
// The input channel in_i carries one beat per sample pair: a ready flag and a
// raw byte for the x and y axes. For each axis the held value takes the new
// byte when its flag is set, is pushed into a WINDOW-deep history kept in one
// synchronous RAM (both axes side by side, a write pointer per item), and the
// signed history sum, kept as a running total, is divided by WINDOW with a
// reciprocal multiply. The average becomes the held value and is scaled to an
// angle of 0 to 358 degrees.
// The output channel out_o sends the line "x=<a>,y=<b>,z=0\r\n", one
// character per beat, 13 to 17 beats, line_end set on the final newline.
// From an input beat to the first character the work runs in this order:
// the history read, the running-sum update, the divide by WINDOW, the angle
// scale and the decimal split, each result held in a register.
// One item is in work at a time: a new input beat is taken only after the
// last character of the line has been loaded into the output register.
// A stalled receiver holds the current character in the output register and
// the block waits; the next input beat is taken while the last character
// of a line still waits. Reset empties the history (entries not yet written
// count as zero) and clears both held values; no clearing pass is needed.
module tilt_average_ascii_reporter #(
  parameter int WINDOW = 10
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tav_in_if.sink    in_i,
  tav_out_if.source out_o
);
  import tav_pkg::*;

  localparam int SUM_W  = $clog2(127*WINDOW+1) + 1;
  localparam int PTR_W  = $clog2(WINDOW);
  localparam int PROD_W = 8 + ANGLE_MULT_W;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(127*WINDOW);

  // Character slots of the longest line; absent digits are skipped.
  localparam logic [4:0] SL_X_CH   = 5'd0;
  localparam logic [4:0] SL_X_EQ   = 5'd1;
  localparam logic [4:0] SL_X_HUND = 5'd2;
  localparam logic [4:0] SL_X_TENS = 5'd3;
  localparam logic [4:0] SL_X_ONES = 5'd4;
  localparam logic [4:0] SL_COMMA1 = 5'd5;
  localparam logic [4:0] SL_Y_CH   = 5'd6;
  localparam logic [4:0] SL_Y_EQ   = 5'd7;
  localparam logic [4:0] SL_Y_HUND = 5'd8;
  localparam logic [4:0] SL_Y_TENS = 5'd9;
  localparam logic [4:0] SL_Y_ONES = 5'd10;
  localparam logic [4:0] SL_COMMA2 = 5'd11;
  localparam logic [4:0] SL_Z_CH   = 5'd12;
  localparam logic [4:0] SL_Z_EQ   = 5'd13;
  localparam logic [4:0] SL_Z_VAL  = 5'd14;
  localparam logic [4:0] SL_CR     = 5'd15;
  localparam logic [4:0] SL_LF     = 5'd16;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_DIV,
    S_SCALE,
    S_DIGIT,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
    logic       ge100;
    logic       ge10;
  } digits_t;

  function automatic digits_t split_dec(input angle_t a);
    digits_t     d;
    angle_t      r;
    logic [14:0] t;
    d.ge100 = a >= 9'd100;
    d.ge10  = a >= 9'd10;
    if (a >= 9'd300) begin
      d.hund = 2'd3;
      r      = a - 9'd300;
    end else if (a >= 9'd200) begin
      d.hund = 2'd2;
      r      = a - 9'd200;
    end else if (a >= 9'd100) begin
      d.hund = 2'd1;
      r      = a - 9'd100;
    end else begin
      d.hund = 2'd0;
      r      = a;
    end
    // Divide by ten as a multiply by 205 and a shift, exact below 1029.
    t      = 15'(r[6:0]) * 15'd205;
    d.tens = t[14:11];
    d.ones = 4'(r[6:0] - 7'(d.tens) * 7'd10);
    return d;
  endfunction

  state_e                   state_q;
  logic [PTR_W-1:0]         ptr_q;
  logic                     wrapped_q;
  logic signed [SUM_W-1:0]  x_sum_q, y_sum_q;
  logic signed [SUM_W-1:0]  x_sum_d, y_sum_d;
  sample_t                  x_held_q, y_held_q;
  sample_t                  x_new_q, y_new_q;
  angle_t                   x_angle_q, y_angle_q;
  digits_t                  x_dig_q, y_dig_q;
  logic [4:0]               slot_q;
  logic                     out_valid_q;
  char_t                    out_char_q;
  logic                     out_last_q;

  logic                     in_accept;
  logic                     out_load;
  logic [15:0]              rd_data;
  sample_t                  x_old, y_old;
  logic                     div_start;
  logic                     x_done, y_done;
  sample_t                  x_avg, y_avg;
  logic [PROD_W-1:0]        x_prod, y_prod;
  char_t                    slot_char;
  logic [4:0]               slot_next;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = state_q == S_IDLE;

  // History RAM: x in the low byte, y in the high byte. The entry at the
  // pointer is the oldest one; it is read at accept and overwritten in the
  // following cycle, and the next read comes only with the next item.
  tav_ram #(
    .WIDTH (16),
    .DEPTH (WINDOW)
  ) u_hist_ram (
    .clk_i     (clk_i),
    .wr_en_i   (state_q == S_UPD),
    .wr_addr_i (ptr_q),
    .wr_data_i ({y_new_q, x_new_q}),
    .rd_en_i   (in_accept),
    .rd_addr_i (ptr_q),
    .rd_data_o (rd_data)
  );

  // Until the pointer has wrapped once, the oldest entry was never written
  // and counts as zero.
  assign x_old = wrapped_q ? rd_data[7:0]  : 8'd0;
  assign y_old = wrapped_q ? rd_data[15:8] : 8'd0;

  assign x_sum_d = x_sum_q - SUM_W'(tav_contrib(x_old)) + SUM_W'(tav_contrib(x_new_q));
  assign y_sum_d = y_sum_q - SUM_W'(tav_contrib(y_old)) + SUM_W'(tav_contrib(y_new_q));

  assign div_start = state_q == S_UPD;

  tav_avg_div #(
    .WINDOW (WINDOW)
  ) u_x_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (x_sum_d),
    .done_o  (x_done),
    .avg_o   (x_avg)
  );

  tav_avg_div #(
    .WINDOW (WINDOW)
  ) u_y_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (y_sum_d),
    .done_o  (y_done),
    .avg_o   (y_avg)
  );

  // Angle is the top bits of the held value times the scaled constant.
  assign x_prod = PROD_W'(x_held_q) * PROD_W'(ANGLE_MULT);
  assign y_prod = PROD_W'(y_held_q) * PROD_W'(ANGLE_MULT);

  always_comb begin
    case (slot_q)
      SL_X_CH:   slot_char = CH_X;
      SL_X_EQ:   slot_char = CH_EQ;
      SL_X_HUND: slot_char = CH_ZERO + 8'(x_dig_q.hund);
      SL_X_TENS: slot_char = CH_ZERO + 8'(x_dig_q.tens);
      SL_X_ONES: slot_char = CH_ZERO + 8'(x_dig_q.ones);
      SL_COMMA1: slot_char = CH_COMMA;
      SL_Y_CH:   slot_char = CH_Y;
      SL_Y_EQ:   slot_char = CH_EQ;
      SL_Y_HUND: slot_char = CH_ZERO + 8'(y_dig_q.hund);
      SL_Y_TENS: slot_char = CH_ZERO + 8'(y_dig_q.tens);
      SL_Y_ONES: slot_char = CH_ZERO + 8'(y_dig_q.ones);
      SL_COMMA2: slot_char = CH_COMMA;
      SL_Z_CH:   slot_char = CH_Z;
      SL_Z_EQ:   slot_char = CH_EQ;
      SL_Z_VAL:  slot_char = CH_ZERO;
      SL_CR:     slot_char = CH_CR;
      default:   slot_char = CH_LF;
    endcase
  end

  // After an equals sign, jump past the leading digits that are absent.
  always_comb begin
    if (slot_q == SL_X_EQ) begin
      slot_next = x_dig_q.ge100 ? SL_X_HUND : (x_dig_q.ge10 ? SL_X_TENS : SL_X_ONES);
    end else if (slot_q == SL_Y_EQ) begin
      slot_next = y_dig_q.ge100 ? SL_Y_HUND : (y_dig_q.ge10 ? SL_Y_TENS : SL_Y_ONES);
    end else begin
      slot_next = slot_q + 5'd1;
    end
  end

  assign out_load = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ptr_q       <= '0;
      wrapped_q   <= 1'b0;
      x_sum_q     <= '0;
      y_sum_q     <= '0;
      x_held_q    <= '0;
      y_held_q    <= '0;
      x_new_q     <= '0;
      y_new_q     <= '0;
      x_angle_q   <= '0;
      y_angle_q   <= '0;
      x_dig_q     <= '0;
      y_dig_q     <= '0;
      slot_q      <= SL_X_CH;
      out_valid_q <= 1'b0;
      out_char_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // While a line is being sent the emit state owns the output register.
      if (out_valid_q && out_o.ready && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            x_new_q <= in_i.x_ready ? in_i.x_sample : x_held_q;
            y_new_q <= in_i.y_ready ? in_i.y_sample : y_held_q;
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          x_sum_q <= x_sum_d;
          y_sum_q <= y_sum_d;
          if (ptr_q == PTR_W'(WINDOW - 1)) begin
            ptr_q     <= '0;
            wrapped_q <= 1'b1;
          end else begin
            ptr_q <= ptr_q + PTR_W'(1);
          end
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (x_done) begin
            x_held_q <= x_avg;
            y_held_q <= y_avg;
            state_q  <= S_SCALE;
          end
        end
        S_SCALE: begin
          x_angle_q <= x_prod[ANGLE_FRAC +: 9];
          y_angle_q <= y_prod[ANGLE_FRAC +: 9];
          state_q   <= S_DIGIT;
        end
        S_DIGIT: begin
          x_dig_q <= split_dec(x_angle_q);
          y_dig_q <= split_dec(y_angle_q);
          slot_q  <= SL_X_CH;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_char_q  <= slot_char;
            out_last_q  <= slot_q == SL_LF;
            if (slot_q == SL_LF) begin
              state_q <= S_IDLE;
            end else begin
              slot_q <= slot_next;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.text_char = out_char_q;
  assign out_o.line_end  = out_last_q;

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> !in_i.ready) else $error("second item taken while one is in work");
  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.line_end |-> out_o.text_char == CH_LF)
    else $error("line end flag on a character other than newline");
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= PTR_W'(WINDOW - 1)) else $error("history pointer out of range");
  a_sum_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_sum_q <= SUM_MAX && x_sum_q >= -SUM_MAX && y_sum_q <= SUM_MAX && y_sum_q >= -SUM_MAX)
    else $error("running sum outside the reachable range");
  a_div_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    x_done == y_done) else $error("axis dividers out of step");
`endif

endmodule

// File: bench/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tav_pkg::*;

  localparam int WINDOW       = 10;
  localparam int RANDOM_ITEMS = 470;
  // The slowest correct run has roughly 500 items, each with up to 17
  // characters under long receiver stalls plus sender gaps and the block's own
  // work per item. The limit leaves a wide margin over that.
  localparam int CYCLE_LIMIT  = 800000;
  localparam int DRAIN_CYCLES = 40;

  // One input beat: ready flags and raw bytes for both axes.
  typedef struct packed {
    logic    x_ready;
    logic    y_ready;
    sample_t x_sample;
    sample_t y_sample;
  } sample_pair_t;

  // One output beat: a character of the report line.
  typedef struct packed {
    char_t text_char;
    logic  line_end;
  } report_char_t;

  // Keeps its own copy of the history and held values of both axes, turns
  // every accepted sample pair into the characters of the report line, and
  // compares the characters that come out of the block against them.
  class tilt_report_model;
    sample_t      history[2][WINDOW];
    sample_t      held[2];
    report_char_t pending_chars[$];
    int unsigned  mismatches;

    function new();
      foreach (history[a, i]) history[a][i] = '0;
      held[0]     = '0;
      held[1]     = '0;
      mismatches  = 0;
    endfunction

    // Shift the held value of one axis into its history and return the
    // new average. A byte above 127 counts as byte minus 255; a negative sum
    // is folded back into the byte range as 255 minus the rounded-up quotient.
    function sample_t slide_and_average(int axis);
      int sum;
      sum = 0;
      for (int i = 0; i + 1 < WINDOW; i++) history[axis][i] = history[axis][i + 1];
      history[axis][WINDOW - 1] = held[axis];
      for (int i = 0; i < WINDOW; i++) begin
        if (history[axis][i] > 8'd127) begin
          sum -= 255 - int'(history[axis][i]);
        end else begin
          sum += int'(history[axis][i]);
        end
      end
      if (sum >= 0) begin
        return sample_t'(sum / WINDOW);
      end
      return sample_t'(255 - ((-sum + WINDOW - 1) / WINDOW));
    endfunction

    function void push_char(char_t c, logic last);
      report_char_t rc;
      rc.text_char = c;
      rc.line_end  = last;
      pending_chars.push_back(rc);
    endfunction

    // Decimal without leading zeros; zero prints as a single digit.
    function void push_angle(angle_t ang);
      if (ang >= 100) push_char(CH_ZERO + char_t'(ang / 100), 1'b0);
      if (ang >= 10) push_char(CH_ZERO + char_t'((ang / 10) % 10), 1'b0);
      push_char(CH_ZERO + char_t'(ang % 10), 1'b0);
    endfunction

    function void note_sample_pair(sample_pair_t sp);
      angle_t x_angle;
      angle_t y_angle;
      if (sp.x_ready) held[0] = sp.x_sample;
      if (sp.y_ready) held[1] = sp.y_sample;
      held[0] = slide_and_average(0);
      held[1] = slide_and_average(1);
      x_angle = angle_t'((int'(held[0]) * 14117) / 10000);
      y_angle = angle_t'((int'(held[1]) * 14117) / 10000);
      push_char(CH_X, 1'b0);
      push_char(CH_EQ, 1'b0);
      push_angle(x_angle);
      push_char(CH_COMMA, 1'b0);
      push_char(CH_Y, 1'b0);
      push_char(CH_EQ, 1'b0);
      push_angle(y_angle);
      push_char(CH_COMMA, 1'b0);
      push_char(CH_Z, 1'b0);
      push_char(CH_EQ, 1'b0);
      push_char(CH_ZERO, 1'b0);
      push_char(CH_CR, 1'b0);
      push_char(CH_LF, 1'b1);
    endfunction

    function void check_char(char_t c, logic last);
      report_char_t exp_char;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, actual char %h line_end %b",
                 $time, c, last);
        mismatches++;
        return;
      end
      exp_char = pending_chars.pop_front();
      if (c !== exp_char.text_char) begin
        $display("%0t: text_char mismatch, expected %h actual %h",
                 $time, exp_char.text_char, c);
        mismatches++;
      end
      if (last !== exp_char.line_end) begin
        $display("%0t: line_end mismatch, expected %b actual %b",
                 $time, exp_char.line_end, last);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  tav_in_if  in_if();
  tav_out_if out_if();

  tilt_average_ascii_reporter #(
    .WINDOW(WINDOW)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source)
  );

  tilt_report_model report_model;
  sample_pair_t     stimulus[$];
  int unsigned      cycle_count;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Raw byte for a run: mostly the corners of the signed reading, where the
  // averages reach their largest angles and the fold of negative sums shows.
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd127;
      2: return 8'd128;
      3: return 8'd254;
      4: return 8'd255;
      default: return sample_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic sample_pair_t make_pair(logic xr, logic yr, sample_t xs, sample_t ys);
    sample_pair_t sp;
    sp.x_ready  = xr;
    sp.y_ready  = yr;
    sp.x_sample = xs;
    sp.y_sample = ys;
    return sp;
  endfunction

  task automatic build_stimulus();
    int      run_left;
    int      run_kind;
    sample_t x_base;
    sample_t y_base;
    run_left = 0;
    run_kind = 0;
    x_base   = '0;
    y_base   = '0;
    // Directed part. A first beat of zeros, then ten beats that fill both
    // histories with the largest positive and the most negative bytes.
    stimulus.push_back(make_pair(1'b1, 1'b1, 8'd0, 8'd0));
    repeat (10) stimulus.push_back(make_pair(1'b1, 1'b1, 8'd127, 8'd128));
    // A history full of 254 gives the largest angle that can be reached,
    // while a history full of 255 reads as zero.
    repeat (10) stimulus.push_back(make_pair(1'b1, 1'b1, 8'd254, 8'd255));
    // With both flags clear the held averages go around the history again.
    repeat (2) stimulus.push_back(make_pair(1'b0, 1'b0, 8'd85, 8'd170));
    // One axis fresh at a time.
    stimulus.push_back(make_pair(1'b1, 1'b0, 8'd255, 8'd0));
    stimulus.push_back(make_pair(1'b0, 1'b1, 8'd0, 8'd1));

    // Random part, in runs. Long runs of one value per axis with fresh flags
    // drive the averages to where the angles have three digits; the rest is
    // fully random content or mostly stale flags.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 16);
        run_kind = $urandom_range(0, 5);
        x_base   = pick_sample();
        y_base   = pick_sample();
      end
      run_left--;
      case (run_kind)
        0, 1: stimulus.push_back(make_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                           sample_t'($urandom), sample_t'($urandom)));
        2: stimulus.push_back(make_pair(1'($urandom_range(0, 3) == 0),
                                        1'($urandom_range(0, 3) == 0),
                                        sample_t'($urandom), sample_t'($urandom)));
        default: stimulus.push_back(make_pair(1'($urandom_range(0, 9) != 0),
                                              1'($urandom_range(0, 9) != 0),
                                              x_base, y_base));
      endcase
    end
  endtask

  // Sends every prepared beat. Beats go out in bursts of random length with
  // random gaps between them; valid stays high through a burst, so one beat
  // follows the next at the first edge the block takes it.
  task automatic send_sample_pairs();
    int burst_left;
    int gap;
    burst_left = 0;
    foreach (stimulus[k]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        if (gap > 0) begin
          in_if.valid = 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        burst_left = $urandom_range(1, 8);
      end
      in_if.valid    = 1'b1;
      in_if.x_ready  = stimulus[k].x_ready;
      in_if.y_ready  = stimulus[k].y_ready;
      in_if.x_sample = stimulus[k].x_sample;
      in_if.y_sample = stimulus[k].y_sample;
      do @(posedge clk_i); while (in_if.ready !== 1'b1);
      @(negedge clk_i);
      burst_left--;
    end
    in_if.valid = 1'b0;
  endtask

  // Receiver backpressure. The pattern switches at random between always ready,
  // coin flips, a fixed one-in-three stall and rare stalls of random length, so
  // that stalls hit every character position.
  initial begin
    int stall_kind;
    int kind_left;
    int stall_left;
    int phase;
    stall_kind    = 0;
    kind_left     = 0;
    stall_left    = 0;
    phase         = 0;
    out_if.ready  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (kind_left == 0) begin
        stall_kind = $urandom_range(0, 3);
        kind_left  = $urandom_range(64, 400);
      end
      kind_left--;
      phase++;
      case (stall_kind)
        0: out_if.ready = 1'b1;
        1: out_if.ready = 1'($urandom_range(0, 1));
        2: out_if.ready = (phase % 3 != 0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_if.ready = 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_left   = $urandom_range(0, 5);
            out_if.ready = 1'b0;
          end else begin
            out_if.ready = 1'b1;
          end
        end
      endcase
    end
  end

  // Both channels are watched at the rising edge. An accepted sample pair is
  // handed to the model before any character of the same edge is checked;
  // the block's own line only starts after its processing states anyway.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        report_model.note_sample_pair(make_pair(in_if.x_ready, in_if.y_ready,
                                                in_if.x_sample, in_if.y_sample));
      end
      if (out_if.valid && out_if.ready) begin
        report_model.check_char(out_if.text_char, out_if.line_end);
      end
    end
  end

  // Watchdog: a lost character or a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cycle_count    = 0;
    report_model   = new();
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.x_ready  = 1'b0;
    in_if.y_ready  = 1'b0;
    in_if.x_sample = '0;
    in_if.y_sample = '0;
    build_stimulus();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_sample_pairs();

    // Every line must come out in full; after the last character a short
    // quiet stretch catches any extra beat the block might still send.
    while (report_model.pending_chars.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (report_model.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/tav_pkg.sv
rtl/tav_in_if.sv
rtl/tav_out_if.sv
rtl/tav_ram.sv
rtl/tav_avg_div.sv
rtl/tilt_average_ascii_reporter.sv
bench/testbench.sv
